// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/trc_pkg.sv -----
package trc_pkg;

    typedef struct packed {
        logic        command;
        logic [2:0]  channel;
        logic [31:0] now_ms;
    } trc_item_t;

    typedef struct packed {
        logic [2:0]  channel_res;
        logic [14:0] rpm;
        logic        last;
    } trc_result_t;

    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic REG_CHANNEL_COUNT = 1'b0;
    localparam logic REG_PPR           = 1'b1;

    localparam int NUM_W = 48;   // edges * 60000
    localparam int DEN_W = 40;   // ppr * elapsed_ms
    localparam int RPM_W = 15;
    localparam int DSH_W = DEN_W + RPM_W;

    localparam logic [15:0]      MS_PER_MIN = 16'd60000;
    localparam logic [RPM_W-1:0] RPM_MAX    = 15'd32767;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_PUSH
    } trc_state_t;

    typedef struct packed {
        logic start;
    } trc_div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } trc_div_stat_t;

endpackage

// ----- rtl/tachometer_rpm_calculator.sv -----
// Multi-channel fan tachometer. An edge transaction bumps one channel's
// 32-bit edge counter without leaving the idle state, so the block is ready
// again in the next cycle. A read transaction latches the elapsed time since
// the previous read and then walks the channels in use in order: for each
// one it forms edges*60000 and ppr*elapsed_ms (ppr = pulses per revolution),
// clears the counter, and runs a 16-step restoring divider that is shared by
// all channels. Per channel the sequencer runs S_MUL, S_DIV_GO, S_DIV_WAIT
// and S_PUSH; item_stall is high for the whole read, result stalls included.
// The divider makes one quotient bit per cycle. The rpm is truncated and
// saturates at 32767; it is 0 when elapsed time or ppr is zero. A result
// may sit in the output register while the next channel is being computed.
module tachometer_rpm_calculator
    import trc_pkg::*;
#(
    parameter int CHANNELS = 6
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  trc_item_t   item,
    output logic        result_valid,
    input  logic        result_stall,
    output trc_result_t result,
    input  logic        wr_en,
    input  logic        wr_index,
    input  logic [7:0]  wr_data
);

    trc_state_t       state_reg, state_next;
    logic [2:0]       cc_reg, cc_next;
    logic [7:0]       ppr_reg, ppr_next;
    logic [31:0]      last_ms_reg, last_ms_next;
    logic [31:0]      elapsed_reg, elapsed_next;
    logic [2:0]       idx_reg, idx_next;
    logic [2:0]       last_idx_reg, last_idx_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] den_reg, den_next;
    trc_result_t      result_reg, result_next;
    logic             result_valid_reg, result_valid_next;

    logic             item_accept;
    logic             inc_en;
    logic             clr_en;
    logic [31:0]      count;
    logic [2:0]       n_act;
    logic             slot_free;
    trc_div_ctrl_t    div_ctrl;
    trc_div_stat_t    div_stat;
    logic [RPM_W-1:0] quot;

    assign item_stall  = (state_reg != S_IDLE);
    assign item_accept = item_valid && !item_stall;
    assign inc_en      = item_accept && (item.command == CMD_EDGE);
    assign slot_free   = !result_valid_reg || !result_stall;

    always_comb
    begin
        if (cc_reg == 3'd0)
        begin
            n_act = 3'd1;
        end
        else if (int'(cc_reg) > CHANNELS)
        begin
            n_act = 3'(CHANNELS);
        end
        else
        begin
            n_act = cc_reg;
        end
    end

    trc_counters #(
        .CHANNELS (CHANNELS)
    ) u_counters (
        .clk    (clk),
        .rst_n  (rst_n),
        .inc_en (inc_en),
        .inc_ch (item.channel),
        .clr_en (clr_en),
        .sel    (idx_reg),
        .count  (count)
    );

    trc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .num   (num_reg),
        .den   (den_reg),
        .stat  (div_stat),
        .quot  (quot)
    );

    // Config writes
    always_comb
    begin
        cc_next  = cc_reg;
        ppr_next = ppr_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_CHANNEL_COUNT: cc_next  = wr_data[2:0];
                REG_PPR:           ppr_next = wr_data;
                default:           ;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        last_ms_next      = last_ms_reg;
        elapsed_next      = elapsed_reg;
        idx_next          = idx_reg;
        last_idx_next     = last_idx_reg;
        num_next          = num_reg;
        den_next          = den_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        clr_en            = 1'b0;
        div_ctrl.start    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (item_accept && item.command == CMD_READ)
                begin
                    elapsed_next  = item.now_ms - last_ms_reg;
                    last_ms_next  = item.now_ms;
                    idx_next      = '0;
                    last_idx_next = n_act - 3'd1;
                    state_next    = S_MUL;
                end
            end
            S_MUL:
            begin
                num_next   = NUM_W'(count) * NUM_W'(MS_PER_MIN);
                den_next   = DEN_W'(ppr_reg) * DEN_W'(elapsed_reg);
                clr_en     = 1'b1;
                state_next = S_DIV_GO;
            end
            S_DIV_GO:
            begin
                div_ctrl.start = 1'b1;
                state_next     = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (slot_free)
                begin
                    result_next.channel_res = idx_reg;
                    result_next.rpm         = quot;
                    result_next.last        = (idx_reg == last_idx_reg);
                    result_valid_next       = 1'b1;
                    if (idx_reg == last_idx_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 3'd1;
                        state_next = S_MUL;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cc_reg           <= 3'd1;
            ppr_reg          <= 8'd2;
            last_ms_reg      <= '0;
            result_valid_reg <= 1'b0;
            idx_reg          <= '0;
            last_idx_reg     <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            cc_reg           <= cc_next;
            ppr_reg          <= ppr_next;
            last_ms_reg      <= last_ms_next;
            result_valid_reg <= result_valid_next;
            idx_reg          <= idx_next;
            last_idx_reg     <= last_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        elapsed_reg <= elapsed_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        result_reg  <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ----- rtl/trc_counters.sv -----
module trc_counters
    import trc_pkg::*;
#(
    parameter int CHANNELS = 6
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        inc_en,
    input  logic [2:0]  inc_ch,
    input  logic        clr_en,
    input  logic [2:0]  sel,
    output logic [31:0] count
);

    logic [31:0] count_reg [CHANNELS];
    logic [31:0] count_next [CHANNELS];

    // Each counter has its own incrementer and clear; an edge on a channel
    // beyond the bank matches no entry and is dropped.
    always_comb
    begin
        for (int k = 0; k < CHANNELS; k++)
        begin
            count_next[k] = count_reg[k];
            if (clr_en && int'(sel) == k)
            begin
                count_next[k] = '0;
            end
            else if (inc_en && int'(inc_ch) == k)
            begin
                count_next[k] = count_reg[k] + 32'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CHANNELS; k++)
            begin
                count_reg[k] <= '0;
            end
        end
        else
        begin
            for (int k = 0; k < CHANNELS; k++)
            begin
                count_reg[k] <= count_next[k];
            end
        end
    end

    always_comb
    begin
        count = '0;
        for (int k = 0; k < CHANNELS; k++)
        begin
            if (int'(sel) == k)
            begin
                count = count_reg[k];
            end
        end
    end

endmodule

// ----- rtl/trc_div.sv -----
module trc_div
    import trc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  trc_div_ctrl_t    ctrl,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output trc_div_stat_t    stat,
    output logic [RPM_W-1:0] quot
);

    // Restoring division, one quotient bit per cycle. The first step tests
    // bit 15: if it would be set the quotient saturates.
    localparam int STEPS = RPM_W + 1;
    localparam int CNT_W = $clog2(STEPS);

    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [DSH_W-1:0] dsh_reg, dsh_next;
    logic [RPM_W-1:0] q_reg, q_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             zero_reg, zero_next;

    logic [DSH_W:0]   diff;
    logic             ge;

    assign diff = {{(DSH_W + 1 - NUM_W){1'b0}}, rem_reg} - {1'b0, dsh_reg};
    assign ge   = !diff[DSH_W];

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        zero_next = zero_reg;
        if (ctrl.start)
        begin
            rem_next  = num;
            dsh_next  = {den, {RPM_W{1'b0}}};
            q_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
            zero_next = (den == '0);
        end
        else if (busy_reg)
        begin
            if (zero_reg)
            begin
                q_next    = '0;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (cnt_reg == '0 && ge)
            begin
                q_next    = RPM_MAX;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                if (ge)
                begin
                    rem_next = diff[NUM_W-1:0];
                end
                q_next   = {q_reg[RPM_W-2:0], ge};
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        q_reg    <= q_next;
        zero_reg <= zero_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = q_reg;

endmodule

// ----- rtl/trc_checker.sv -----
`include "assert_macros.svh"

module trc_checker
    import trc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_stall,
    input trc_item_t   item,
    input logic        result_valid,
    input logic        result_stall,
    input trc_result_t result,
    input logic        wr_en,
    input logic        wr_index,
    input logic [7:0]  wr_data
);

    logic edge_acc;
    logic read_acc;
    logic cfg_seen;

    assign edge_acc = item_valid && !item_stall && (item.command == CMD_EDGE);
    assign read_acc = item_valid && !item_stall && (item.command == CMD_READ);
    assign cfg_seen = wr_en && (wr_index == REG_CHANNEL_COUNT || wr_data != 8'd0);

    // A held result stays put until it is taken.
    `ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result))

    // An edge transaction taken without a config write leaves the block unstalled in the next cycle.
    `ASSERT_NEXT(a_edge_fast, clk, rst_n, edge_acc && !cfg_seen, !item_stall)

    // A read always occupies the block for at least the following cycle.
    `ASSERT_NEXT(a_read_busy, clk, rst_n, read_acc, item_stall)

    // A new result only comes out of an active read.
    `ASSERT_IMPLIES(a_result_source, clk, rst_n, $rose(result_valid), $past(item_stall))

endmodule

bind tachometer_rpm_calculator trc_checker u_trc_checker (.*);
